// ===== rtl/vdcw_pkg.sv =====
// Shared types and constants for the descriptor chain walker.
package vdcw_pkg;

  localparam int ADDR_W = 64;
  localparam int LEN_W  = 32;
  localparam int IDX_W  = 16;
  localparam int FLAG_W = 2;
  localparam int QSZ_W  = 6;
  localparam int ST_W   = 3;

  // flag bits of a descriptor
  localparam int FLAG_NEXT_BIT  = 0;
  localparam int FLAG_WRITE_BIT = 1;

  localparam logic [QSZ_W-1:0] QSZ_RESET = 6'd32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_WALK  = 1'b1;

  localparam logic KIND_SEG  = 1'b0;
  localparam logic KIND_STAT = 1'b1;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 3'd1;
  localparam logic [ST_W-1:0] ST_WRONG_DIR = 3'd2;
  localparam logic [ST_W-1:0] ST_SHORT     = 3'd3;
  localparam logic [ST_W-1:0] ST_TOO_LONG  = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [FLAG_W-1:0] flags;
    logic [IDX_W-1:0]  next;
  } desc_entry_t;

  // controller to datapath
  typedef struct packed {
    logic            wr_entry;
    logic            start;
    logic            rd_en;
    logic            eval_en;
    logic            seg_load;
    logic            stat_load;
    logic [ST_W-1:0] stat_code;
    logic            follow;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_oob;
    logic dir_bad;
    logic hit;
    logic rem_zero;
    logic chain_next;
    logic visited_full;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/vdcw_datapath.sv =====
// Datapath: descriptor table, walk registers, segment trimming and result register.
module vdcw_datapath import vdcw_pkg::*; #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [QSZ_W-1:0]  cfg_wr_data,
  input  logic [IDX_W-1:0]  in_desc_index,
  input  logic [ADDR_W-1:0] in_entry_addr,
  input  logic [LEN_W-1:0]  in_entry_len,
  input  logic [FLAG_W-1:0] in_entry_flags,
  input  logic [IDX_W-1:0]  in_entry_next,
  input  logic [LEN_W-1:0]  in_walk_offset,
  input  logic [LEN_W-1:0]  in_walk_length,
  input  logic              in_want_writable,
  input  ctl_cmd_t          cmd,
  output dp_stat_t          stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_result_kind,
  output logic [ADDR_W-1:0] out_seg_addr,
  output logic [LEN_W-1:0]  out_seg_len,
  output logic [ST_W-1:0]   out_status,
  output logic              out_last
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(QUEUE_DEPTH);
  localparam logic [QSZ_W-1:0] DEPTH_QSZ = QSZ_W'(QUEUE_DEPTH);

  desc_entry_t mem [QUEUE_DEPTH];
  desc_entry_t rd_q;

  logic [QSZ_W-1:0]  qsz_r;
  logic [QSZ_W-1:0]  qsize;
  logic [IDX_W-1:0]  idx_r;
  logic [LEN_W-1:0]  skip_r;
  logic [LEN_W-1:0]  rem_r;
  logic              want_wr_r;
  logic              past_r;
  logic [QSZ_W-1:0]  visited_r;
  logic              hit_r;
  logic [LEN_W-1:0]  lraw_r;
  logic [ADDR_W-1:0] sega_r;
  logic              chain_next_r;
  logic [IDX_W-1:0]  next_r;
  logic              out_valid_r;

  logic              hit_now;
  logic              clip;
  logic [LEN_W-1:0]  seg_len;
  logic [LEN_W-1:0]  rem_nxt;

  // effective queue size
  assign qsize = (qsz_r < DEPTH_QSZ) ? qsz_r : DEPTH_QSZ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qsz_r <= QSZ_RESET;
    end else if (cfg_wr_en) begin
      qsz_r <= cfg_wr_data;
    end
  end

  // descriptor table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_entry && (in_desc_index < DEPTH_IDX)) begin
      mem[in_desc_index[AW-1:0]] <= '{addr: in_entry_addr, len: in_entry_len,
                                      flags: in_entry_flags, next: in_entry_next};
    end
    if (cmd.rd_en) begin
      rd_q <= mem[idx_r[AW-1:0]];
    end
  end

  // a descriptor holds wanted bytes once the chain has passed the offset
  assign hit_now = past_r || (rd_q.len > skip_r);

  // trim to what is still wanted
  assign clip    = lraw_r > rem_r;
  assign seg_len = clip ? rem_r : lraw_r;
  assign rem_nxt = clip ? '0 : rem_r - lraw_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_r     <= in_desc_index;
      skip_r    <= in_walk_offset;
      rem_r     <= in_walk_length;
      want_wr_r <= in_want_writable;
    end else begin
      if (cmd.eval_en) begin
        hit_r        <= hit_now;
        lraw_r       <= rd_q.len - skip_r;
        sega_r       <= rd_q.addr + {{(ADDR_W-LEN_W){1'b0}}, skip_r};
        chain_next_r <= rd_q.flags[FLAG_NEXT_BIT];
        next_r       <= rd_q.next;
        skip_r       <= hit_now ? '0 : skip_r - rd_q.len;
      end
      if (cmd.seg_load) begin
        rem_r <= rem_nxt;
      end
      if (cmd.follow) begin
        idx_r <= next_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      past_r    <= 1'b0;
      visited_r <= '0;
    end else if (cmd.start) begin
      past_r    <= 1'b0;
      visited_r <= '0;
    end else if (cmd.eval_en) begin
      past_r    <= past_r | hit_now;
      visited_r <= visited_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.seg_load || cmd.stat_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      out_result_kind <= KIND_SEG;
      out_seg_addr    <= sega_r;
      out_seg_len     <= seg_len;
      out_status      <= ST_OK;
      out_last        <= 1'b0;
    end else if (cmd.stat_load) begin
      out_result_kind <= KIND_STAT;
      out_seg_addr    <= '0;
      out_seg_len     <= '0;
      out_status      <= cmd.stat_code;
      out_last        <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  assign stat.idx_oob      = idx_r >= {{(IDX_W-QSZ_W){1'b0}}, qsize};
  assign stat.dir_bad      = rd_q.flags[FLAG_WRITE_BIT] != want_wr_r;
  assign stat.hit          = hit_r;
  assign stat.rem_zero     = rem_nxt == '0;
  assign stat.chain_next   = chain_next_r;
  assign stat.visited_full = visited_r >= qsize;
  assign stat.out_free     = !out_valid_r || out_ready;

endmodule

// ===== rtl/vdcw_ctrl.sv =====
// Controller: sequences entry writes and chain walks over the datapath.
module vdcw_ctrl import vdcw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_command,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_STAT  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [ST_W-1:0] code_r, code_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    cmd           = '0;
    cmd.stat_code = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_WALK) begin
            cmd.start = 1'b1;
            state_nxt = S_CHECK;
          end else begin
            cmd.wr_entry = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (stat.idx_oob) begin
          code_nxt  = ST_BAD_INDEX;
          state_nxt = S_STAT;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.dir_bad) begin
          code_nxt  = ST_WRONG_DIR;
          state_nxt = S_STAT;
        end else begin
          cmd.eval_en = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.hit || stat.out_free) begin
          cmd.seg_load = stat.hit;
          if (stat.hit && stat.rem_zero) begin
            code_nxt  = ST_OK;
            state_nxt = S_STAT;
          end else if (!stat.chain_next) begin
            code_nxt  = ST_SHORT;
            state_nxt = S_STAT;
          end else if (stat.visited_full) begin
            code_nxt  = ST_TOO_LONG;
            state_nxt = S_STAT;
          end else begin
            cmd.follow = 1'b1;
            state_nxt  = S_CHECK;
          end
        end
      end
      S_STAT: begin
        if (stat.out_free) begin
          cmd.stat_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

// ===== rtl/virtq_desc_chain_walker_core.sv =====
// Top level of the split-ring descriptor chain walker.
// Usage:
//   Input channel (in_valid/in_ready) carries one command per beat. A write
//   beat (command 0) loads one descriptor into the table in the accepting
//   cycle; indices at or beyond QUEUE_DEPTH are dropped. A walk beat
//   (command 1) follows the chain from in_desc_index, skipping in_walk_offset
//   bytes and delivering at most in_walk_length bytes.
//   Output channel (out_valid/out_ready) gives zero or more segment beats and
//   then exactly one status beat with out_last set.
//   cfg_wr_en/cfg_wr_data set the queue size in use; write it only when idle.
// Timing:
//   A write leaves the controller idle, so a beat can follow in the next cycle.
//   A walk visits one descriptor at a time in steps: index check and table
//   read, then length and direction evaluation, then trim and emit; the emit
//   step waits for a free result register when it has a segment to give.
//   A new command is taken only once the previous walk has queued its status.
// Reset and stall:
//   rst_n (synchronous) clears the controller and the result valid flag and sets
//   the queue size to 32; table contents stay undefined until written.
//   A stalled receiver holds the result register and the walk waits for it.
module virtq_desc_chain_walker_core import vdcw_pkg::*; #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [QSZ_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [IDX_W-1:0]  in_desc_index,
  input  logic [ADDR_W-1:0] in_entry_addr,
  input  logic [LEN_W-1:0]  in_entry_len,
  input  logic [FLAG_W-1:0] in_entry_flags,
  input  logic [IDX_W-1:0]  in_entry_next,
  input  logic [LEN_W-1:0]  in_walk_offset,
  input  logic [LEN_W-1:0]  in_walk_length,
  input  logic              in_want_writable,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_result_kind,
  output logic [ADDR_W-1:0] out_seg_addr,
  output logic [LEN_W-1:0]  out_seg_len,
  output logic [ST_W-1:0]   out_status,
  output logic              out_last
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencing: one descriptor at a time, waits on the result register
  vdcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // table, walk arithmetic and the output register
  vdcw_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_desc_index    (in_desc_index),
    .in_entry_addr    (in_entry_addr),
    .in_entry_len     (in_entry_len),
    .in_entry_flags   (in_entry_flags),
    .in_entry_next    (in_entry_next),
    .in_walk_offset   (in_walk_offset),
    .in_walk_length   (in_walk_length),
    .in_want_writable (in_want_writable),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_result_kind  (out_result_kind),
    .out_seg_addr     (out_seg_addr),
    .out_seg_len      (out_seg_len),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

// ===== verif/vdcw_chain_checker.sv =====
// Watches the walker's channels, predicts every result beat and compares it.
module vdcw_chain_checker import vdcw_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [QSZ_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_command,
  input  logic [IDX_W-1:0]  in_desc_index,
  input  logic [ADDR_W-1:0] in_entry_addr,
  input  logic [LEN_W-1:0]  in_entry_len,
  input  logic [FLAG_W-1:0] in_entry_flags,
  input  logic [IDX_W-1:0]  in_entry_next,
  input  logic [LEN_W-1:0]  in_walk_offset,
  input  logic [LEN_W-1:0]  in_walk_length,
  input  logic              in_want_writable,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_result_kind,
  input  logic [ADDR_W-1:0] out_seg_addr,
  input  logic [LEN_W-1:0]  out_seg_len,
  input  logic [ST_W-1:0]   out_status,
  input  logic              out_last,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [ST_W-1:0]   status;
    logic              last;
  } walk_beat_t;

  logic [ADDR_W-1:0] ring_addr  [DEPTH];
  logic [LEN_W-1:0]  ring_len   [DEPTH];
  logic [FLAG_W-1:0] ring_flags [DEPTH];
  logic [IDX_W-1:0]  ring_next  [DEPTH];
  logic [QSZ_W-1:0]  q_in_use;

  walk_beat_t beats_due[$];
  int mismatches = 0;
  int beats_seen = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] walker check: %s", $time, msg);
  endtask

  function automatic void queue_beat(input logic kind, input logic [ADDR_W-1:0] addr,
                                     input logic [LEN_W-1:0] len,
                                     input logic [ST_W-1:0] status);
    walk_beat_t b;
    b.kind = kind;
    b.addr = addr;
    b.len = len;
    b.status = status;
    b.last = (kind == KIND_STAT);
    beats_due.push_back(b);
  endfunction

  // Segments of one walk followed by its closing status.
  function automatic void predict_walk(input logic [IDX_W-1:0] head,
                                       input logic [LEN_W-1:0] offs_in,
                                       input logic [LEN_W-1:0] want_in,
                                       input logic wr);
    int unsigned lim, visited, cur;
    logic [63:0] offs, want, done, o, dlen, l;
    logic [ADDR_W-1:0] a;
    logic [FLAG_W-1:0] fl;
    logic finished;
    lim = (q_in_use < DEPTH) ? 32'(q_in_use) : DEPTH;
    cur = 32'(head);
    offs = 64'(offs_in);
    want = 64'(want_in);
    done = '0;
    o = '0;
    visited = 0;
    finished = 1'b0;
    while (!finished) begin
      if (cur >= lim) begin
        queue_beat(KIND_STAT, '0, '0, ST_BAD_INDEX);
        finished = 1'b1;
      end else begin
        fl = ring_flags[cur];
        if (fl[FLAG_WRITE_BIT] != wr) begin
          queue_beat(KIND_STAT, '0, '0, ST_WRONG_DIR);
          finished = 1'b1;
        end else begin
          visited++;
          dlen = 64'(ring_len[cur]);
          if (dlen + o > offs) begin
            if (o < offs) begin
              a = ring_addr[cur] + (offs - o);
              l = dlen - (offs - o);
            end else begin
              a = ring_addr[cur];
              l = dlen;
            end
            if (l > want - done) l = want - done;
            queue_beat(KIND_SEG, a, l[LEN_W-1:0], ST_OK);
            done += l;
            if (done == want) begin
              queue_beat(KIND_STAT, '0, '0, ST_OK);
              finished = 1'b1;
            end
          end
          if (!finished) begin
            o += dlen;
            if (!fl[FLAG_NEXT_BIT]) begin
              queue_beat(KIND_STAT, '0, '0, ST_SHORT);
              finished = 1'b1;
            end else if (visited >= lim) begin
              queue_beat(KIND_STAT, '0, '0, ST_TOO_LONG);
              finished = 1'b1;
            end else begin
              cur = 32'(ring_next[cur]);
            end
          end
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    walk_beat_t exp;
    if (!rst_n) begin
      q_in_use = QSZ_RESET;
      beats_due.delete();
    end else begin
      // output first: a beat leaving now never belongs to a walk taken now
      if (out_valid && out_ready) begin
        beats_seen++;
        if (beats_due.size() == 0) begin
          report_mismatch($sformatf("beat %0d arrived with nothing outstanding", beats_seen));
        end else begin
          exp = beats_due.pop_front();
          if (out_result_kind !== exp.kind || out_seg_addr !== exp.addr ||
              out_seg_len !== exp.len || out_status !== exp.status ||
              out_last !== exp.last)
            report_mismatch($sformatf(
              "beat %0d got kind %0d addr %h len %h st %0d last %0d, want %0d %h %h %0d %0d",
              beats_seen, out_result_kind, out_seg_addr, out_seg_len, out_status, out_last,
              exp.kind, exp.addr, exp.len, exp.status, exp.last));
        end
      end
      if (cfg_wr_en) q_in_use = cfg_wr_data;
      if (in_valid && in_ready) begin
        if (in_command == CMD_WRITE) begin
          if (in_desc_index < DEPTH) begin
            ring_addr[in_desc_index]  = in_entry_addr;
            ring_len[in_desc_index]   = in_entry_len;
            ring_flags[in_desc_index] = in_entry_flags;
            ring_next[in_desc_index]  = in_entry_next;
          end
        end else begin
          predict_walk(in_desc_index, in_walk_offset, in_walk_length, in_want_writable);
        end
      end
    end
    pending <= beats_due.size();
    fail_count <= mismatches;
  end

endmodule

// ===== verif/virtq_desc_chain_walker_core_test.sv =====
// Stimulus, handshake driving and verdict for the descriptor chain walker.
module virtq_desc_chain_walker_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vdcw_pkg::*;

  localparam int DEPTH       = 32;
  localparam int QUIET_LIMIT = 4000;  // cycles with no beat on either channel
  localparam int HOLD_CYCLES = 300;   // the one long receiver hold-off
  localparam int SETTLE      = 10;    // idle cycles before a register write / the verdict
  localparam int PICK_RANDOM = -1;

  localparam logic [FLAG_W-1:0] F_NEXT  = FLAG_W'(1 << FLAG_NEXT_BIT);
  localparam logic [FLAG_W-1:0] F_WRITE = FLAG_W'(1 << FLAG_WRITE_BIT);

  // one command beat on the input channel
  typedef struct {
    logic              command;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [FLAG_W-1:0] flags;
    logic [IDX_W-1:0]  next;
    logic [LEN_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
    logic              writable;
  } ring_cmd_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [QSZ_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_command = CMD_WRITE;
  logic [IDX_W-1:0]  in_desc_index = '0;
  logic [ADDR_W-1:0] in_entry_addr = '0;
  logic [LEN_W-1:0]  in_entry_len = '0;
  logic [FLAG_W-1:0] in_entry_flags = '0;
  logic [IDX_W-1:0]  in_entry_next = '0;
  logic [LEN_W-1:0]  in_walk_offset = '0;
  logic [LEN_W-1:0]  in_walk_length = '0;
  logic              in_want_writable = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_result_kind;
  logic [ADDR_W-1:0] out_seg_addr;
  logic [LEN_W-1:0]  out_seg_len;
  logic [ST_W-1:0]   out_status;
  logic              out_last;

  int  fail_count;
  int  pending;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  logic gaps_on = 1'b1;   // random idling on both sides
  logic squeeze = 1'b0;   // asks the receiver for its long hold-off
  logic squeezed = 1'b0;

  // queue size per phase; the directed cases before them run on the reset value
  int size_plan [8] = '{1, 0, 32, PICK_RANDOM, 31, 2, PICK_RANDOM, 32};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  virtq_desc_chain_walker_core #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_desc_index    (in_desc_index),
    .in_entry_addr    (in_entry_addr),
    .in_entry_len     (in_entry_len),
    .in_entry_flags   (in_entry_flags),
    .in_entry_next    (in_entry_next),
    .in_walk_offset   (in_walk_offset),
    .in_walk_length   (in_walk_length),
    .in_want_writable (in_want_writable),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_seg_addr     (out_seg_addr),
    .out_seg_len      (out_seg_len),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  vdcw_chain_checker #(.DEPTH(DEPTH)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_desc_index    (in_desc_index),
    .in_entry_addr    (in_entry_addr),
    .in_entry_len     (in_entry_len),
    .in_entry_flags   (in_entry_flags),
    .in_entry_next    (in_entry_next),
    .in_walk_offset   (in_walk_offset),
    .in_walk_length   (in_walk_length),
    .in_want_writable (in_want_writable),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_seg_addr     (out_seg_addr),
    .out_seg_len      (out_seg_len),
    .out_status       (out_status),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Receiver: random stalls, plus one long hold-off counted here so that the
  // result register fills, the walk blocks and in_ready drops while the
  // sender keeps a beat on offer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (squeeze && !squeezed) begin
      out_ready <= 1'b0;
      squeezed <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= !gaps_on || ($urandom_range(99) >= 26);
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("virtq_desc_chain_walker_core: mismatch");
      $finish;
    end
  end

  // Every field random, so that bits unused by the command still toggle.
  function automatic ring_cmd_t scrambled_cmd();
    ring_cmd_t c;
    c.command  = 1'($urandom_range(1));
    c.index    = IDX_W'($urandom);
    c.addr     = {$urandom, $urandom};
    c.len      = $urandom;
    c.flags    = FLAG_W'($urandom_range(3));
    c.next     = IDX_W'($urandom);
    c.offset   = $urandom;
    c.length   = $urandom;
    c.writable = 1'($urandom_range(1));
    return c;
  endfunction

  // Called in the step of a rising edge; returns in the step of the edge that
  // took the beat, with valid still high so back-to-back beats need no toggle.
  task automatic send_cmd(input ring_cmd_t c);
    while (gaps_on && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= c.command;
    in_desc_index    <= c.index;
    in_entry_addr    <= c.addr;
    in_entry_len     <= c.len;
    in_entry_flags   <= c.flags;
    in_entry_next    <= c.next;
    in_walk_offset   <= c.offset;
    in_walk_length   <= c.length;
    in_want_writable <= c.writable;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_desc(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] addr,
                          input logic [LEN_W-1:0] len, input logic [FLAG_W-1:0] flags,
                          input logic [IDX_W-1:0] next);
    ring_cmd_t c;
    c = scrambled_cmd();
    c.command = CMD_WRITE;
    c.index = idx;
    c.addr = addr;
    c.len = len;
    c.flags = flags;
    c.next = next;
    send_cmd(c);
  endtask

  task automatic walk_from(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] offs,
                           input logic [LEN_W-1:0] want, input logic wr);
    ring_cmd_t c;
    c = scrambled_cmd();
    c.command = CMD_WALK;
    c.index = idx;
    c.offset = offs;
    c.length = want;
    c.writable = wr;
    send_cmd(c);
  endtask

  // Drop valid, let every outstanding beat come back, then let the block
  // settle (a trailing write may still be in flight).
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_queue_size(input logic [QSZ_W-1:0] size);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Well-formed chain: k linked descriptors on distinct in-range slots with
  // one direction, then a walk of it with offset and length around its size.
  // Now and then a descriptor has the wrong direction, the tail links on
  // (back to the head or anywhere), or the walk asks the other way.
  task automatic send_chain(input int qs);
    int unsigned perm [DEPTH];
    int j, t, sw, k;
    logic dir;
    logic [63:0] total;
    logic [LEN_W-1:0] offs, want;
    ring_cmd_t c;
    for (j = 0; j < qs; j++) perm[j] = j;
    for (j = qs - 1; j > 0; j--) begin
      t = $urandom_range(0, j);
      sw = perm[j];
      perm[j] = perm[t];
      perm[t] = sw;
    end
    k = ($urandom_range(5) == 0) ? $urandom_range(1, qs) : $urandom_range(1, (qs < 5) ? qs : 5);
    dir = 1'($urandom_range(1));
    total = '0;
    for (j = 0; j < k; j++) begin
      c = scrambled_cmd();
      c.command = CMD_WRITE;
      c.index = IDX_W'(perm[j]);
      c.len = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 64);
      c.flags = F_NEXT | (dir ? F_WRITE : '0);
      if ($urandom_range(11) == 0) c.flags ^= F_WRITE;
      if (j < k - 1) begin
        c.next = IDX_W'(perm[j + 1]);
      end else begin
        if ($urandom_range(6) != 0) c.flags &= ~F_NEXT;
        if ($urandom_range(1) == 1) c.next = IDX_W'(perm[0]);
      end
      total += c.len;
      send_cmd(c);
    end
    if (total > 64'd10000) begin
      offs = ($urandom_range(3) == 0) ? '0 : $urandom;
      want = $urandom;
    end else begin
      offs = ($urandom_range(3) == 0) ? '0 : $urandom_range(0, 32'(total));
      want = $urandom_range(0, 32'(total - 64'(offs) + 64'd4));
    end
    walk_from(IDX_W'(perm[0]), offs, want, dir ^ ($urandom_range(14) == 0));
  endtask

  initial begin : stimulus
    int p, qs, quota, first, r, i;
    ring_cmd_t c;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every slot first: nothing ever walks into an unwritten entry.
    for (i = 0; i < DEPTH; i++)
      put_desc(IDX_W'(i), {$urandom, $urandom}, $urandom_range(1, 64), F_NEXT,
               IDX_W'((i + 1) % DEPTH));

    // Directed cases, queue size at its reset value.
    put_desc(0, 64'hFFFF_FFFF_FFFF_FFF0, 32, F_NEXT, 1);
    put_desc(1, 64'h0000_0000_0000_1000, 32'hFFFF_FFFF, '0, 16'hFFFF);
    walk_from(0, 20, 32'hFFFF_FFFF, 1'b0);             // offset inside, address wraps
    walk_from(0, 0, 0, 1'b0);                          // zero length wanted
    walk_from(0, 32, 7, 1'b0);                         // offset on a descriptor edge
    walk_from(0, 32'hFFFF_FFFF, 5, 1'b0);              // largest offset
    walk_from(0, 0, 64, 1'b1);                         // direction mismatch
    put_desc(2, {$urandom, $urandom}, 8, F_WRITE, '0);
    walk_from(2, 0, 100, 1'b1);                        // chain ends short
    put_desc(3, {$urandom, $urandom}, 4, F_NEXT | F_WRITE, 16'hFFFF);
    walk_from(3, 0, 100, 1'b1);                        // link leaves the table
    walk_from(16'hFFFF, 0, 10, 1'b0);                  // head index out of range
    walk_from(DEPTH, 0, 10, 1'b0);                     // first index past the end
    put_desc(16'hFFFF, '1, '1, '1, '1);                // dropped write
    put_desc(DEPTH, '1, '1, '1, '1);                   // dropped write
    walk_from(DEPTH - 1, 0, 32'hFFFF_FFFF, 1'b0);
    put_desc(4, {$urandom, $urandom}, 16, F_NEXT | F_WRITE, 4);
    walk_from(4, 0, 32'hFFFF_FFFF, 1'b1);              // self loop: full run, too long
    put_desc(5, {$urandom, $urandom}, 0, F_NEXT, 6);
    put_desc(6, '0, 10, '0, '0);
    walk_from(5, 0, 3, 1'b0);                          // empty descriptor skipped
    walk_from(5, 0, 10, 1'b0);                         // length met on the last byte
    walk_from(5, 10, 1, 1'b0);                         // offset at the chain's end

    // Random phases, one queue size each. Phase 2 carries the long receiver
    // hold-off; the last phase runs with no idling at all.
    for (p = 0; p < 8; p++) begin
      qs = (size_plan[p] == PICK_RANDOM) ? $urandom_range(3, 30) : size_plan[p];
      wait_idle();
      set_queue_size(QSZ_W'(qs));
      gaps_on <= (p != 7);
      quota = (qs == 0) ? 20 : 48;
      first = items_sent;
      while (items_sent - first < quota) begin
        if (p == 2 && items_sent - first >= 10) squeeze <= 1'b1;
        r = $urandom_range(99);
        if (qs != 0 && r < 70) begin
          send_chain(qs);
        end else if (r < 85) begin
          c = scrambled_cmd();
          c.command = CMD_WRITE;
          if ($urandom_range(1) == 1) c.index = IDX_W'($urandom_range(0, DEPTH - 1));
          if ($urandom_range(1) == 1) c.next = IDX_W'($urandom_range(0, qs + 1));
          send_cmd(c);
        end else begin
          c = scrambled_cmd();
          c.command = CMD_WALK;
          if ($urandom_range(1) == 1) c.index = IDX_W'($urandom_range(0, qs + 2));
          if ($urandom_range(1) == 1) c.offset = $urandom_range(0, 200);
          if ($urandom_range(1) == 1) c.length = $urandom_range(0, 200);
          send_cmd(c);
        end
      end
    end

    wait_idle();
    if (fail_count == 0 && pending == 0)
      $display("virtq_desc_chain_walker_core: match");
    else
      $display("virtq_desc_chain_walker_core: mismatch");
    $finish;
  end

endmodule

// ===== virtq_desc_chain_walker_core.f =====
rtl/vdcw_pkg.sv
rtl/vdcw_datapath.sv
rtl/vdcw_ctrl.sv
rtl/virtq_desc_chain_walker_core.sv
verif/vdcw_chain_checker.sv
verif/virtq_desc_chain_walker_core_test.sv
